// ===== rtl/core/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// shared constants, types and the power table builder for the lux calculator
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int RATIO_FRAC_BITS = 10;
    localparam int LUX_FRAC_BITS   = 8;

    localparam int CH_W    = 16;
    localparam int LUX_W   = 19;
    localparam int SEG_W   = 3;
    localparam int COEF_W  = 16;
    localparam int POS_W   = 31;   // largest positive coefficient is below 2^15
    localparam int NEG_W   = 32;
    localparam int Q_SHIFT = 20;   // coefficient fraction bits
    localparam int WIDE_W  = NEG_W + Q_SHIFT;
    localparam int POW_W   = 19;   // r^1.4 in q0.20 for r <= 0.5
    localparam int IDX_W   = RATIO_FRAC_BITS;
    localparam int ROM_DEPTH = (1 << (RATIO_FRAC_BITS - 1)) + 1;
    localparam int CMP_W   = 24;
    localparam int LUX_SHIFT = 2 * Q_SHIFT - LUX_FRAC_BITS;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    // breakpoint scale factors, ratio compared as ch1 * 100 against ch0 * k
    localparam logic [CMP_W-1:0] BRK_SCALE = 24'd100;
    localparam logic [CMP_W-1:0] BRK_B     = 24'd61;
    localparam logic [CMP_W-1:0] BRK_C     = 24'd80;
    localparam logic [CMP_W-1:0] BRK_D     = 24'd130;

    // q0.20 coefficients
    localparam logic [COEF_W-1:0] K_A0 = 16'd31877;
    localparam logic [COEF_W-1:0] K_A1 = 16'd65012;
    localparam logic [COEF_W-1:0] K_B0 = 16'd23488;
    localparam logic [COEF_W-1:0] K_B1 = 16'd32506;
    localparam logic [COEF_W-1:0] K_C0 = 16'd13422;
    localparam logic [COEF_W-1:0] K_C1 = 16'd16043;
    localparam logic [COEF_W-1:0] K_D0 = 16'd1531;
    localparam logic [COEF_W-1:0] K_D1 = 16'd1174;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_ZERO = 3'd0;
    localparam logic [SEG_W-1:0] SEG_1    = 3'd1;
    localparam logic [SEG_W-1:0] SEG_2    = 3'd2;
    localparam logic [SEG_W-1:0] SEG_3    = 3'd3;
    localparam logic [SEG_W-1:0] SEG_4    = 3'd4;
    localparam logic [SEG_W-1:0] SEG_HIGH = 3'd5;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [POS_W-1:0] pos;
        logic [NEG_W-1:0] neg;
        logic [CH_W-1:0]  rem;
        logic [CH_W-1:0]  dvsr;
        logic [IDX_W-1:0] quo;
    } tlc_div_t;

    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [POS_W-1:0]  pos;
        logic [WIDE_W-1:0] neg;
    } tlc_fin_t;

    typedef logic [POW_W-1:0] tlc_pow_rom_t [ROM_DEPTH];

    // elaboration-time build of y = (r16 * floor(r^0.4 in q0.12)) >> 8
    function automatic tlc_pow_rom_t tlc_pow_rom();
        tlc_pow_rom_t rom;
        logic [63:0]  r16;
        logic [63:0]  v;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  p;
        logic [63:0]  y;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            r16 = 64'(i) << (16 - RATIO_FRAC_BITS);
            v   = (r16 * r16) << 28;
            lo  = 64'd0;
            hi  = 64'd4095;
            for (int k = 0; k < 13; k++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    p   = mid * mid;
                    p   = p * p * mid;
                    if (p <= v) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            y      = (r16 * lo) >> 8;
            rom[i] = y[POW_W-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/tlc_classify.sv =====
// ----------------------------------------------------------------------------
// tlc_classify
// segment choice by ratio breakpoints, then coefficient products
// ----------------------------------------------------------------------------
module tlc_classify import tlc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CH_W-1:0] s_ch0,
    input  logic [CH_W-1:0] s_ch1,
    output logic            m_valid,
    input  logic            m_ready,
    output tlc_div_t        m_data
);

    logic             va_reg;
    logic             vb_reg;
    logic             en_a;
    logic             en_b;
    logic [CH_W-1:0]  ch0_reg;
    logic [CH_W-1:0]  ch1_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_next;
    logic [CMP_W-1:0] ch1_x100;
    tlc_div_t         data_reg;
    tlc_div_t         data_next;
    logic [COEF_W-1:0] pos_c;
    logic [COEF_W-1:0] neg_c;
    logic [CH_W-1:0]   neg_x;
    logic [31:0]       pos_prod;

    assign en_b    = !vb_reg || m_ready;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;
    assign m_valid = vb_reg;
    assign m_data  = data_reg;

    assign ch1_x100 = CMP_W'(s_ch1) * BRK_SCALE;

    always_comb begin
        if (s_ch0 == '0) begin
            seg_next = SEG_ZERO;
        end else if ({s_ch1, 1'b0} <= {1'b0, s_ch0}) begin
            seg_next = SEG_1;
        end else if (ch1_x100 <= CMP_W'(s_ch0) * BRK_B) begin
            seg_next = SEG_2;
        end else if (ch1_x100 <= CMP_W'(s_ch0) * BRK_C) begin
            seg_next = SEG_3;
        end else if (ch1_x100 <= CMP_W'(s_ch0) * BRK_D) begin
            seg_next = SEG_4;
        end else begin
            seg_next = SEG_HIGH;
        end
    end

    always_comb begin
        pos_c = '0;
        neg_c = '0;
        neg_x = ch1_reg;
        case (seg_reg)
            SEG_1: begin
                pos_c = K_A0;
                neg_c = K_A1;
                neg_x = ch0_reg;   // multiplied by r^1.4 further down
            end
            SEG_2: begin
                pos_c = K_B0;
                neg_c = K_B1;
            end
            SEG_3: begin
                pos_c = K_C0;
                neg_c = K_C1;
            end
            SEG_4: begin
                pos_c = K_D0;
                neg_c = K_D1;
            end
            default: begin
                pos_c = '0;
                neg_c = '0;
            end
        endcase
        pos_prod       = 32'(pos_c) * 32'(ch0_reg);
        data_next.seg  = seg_reg;
        data_next.pos  = pos_prod[POS_W-1:0];
        data_next.neg  = NEG_W'(32'(neg_c) * 32'(neg_x));
        // only segment 1 needs the ratio; others divide zero by one
        data_next.rem  = (seg_reg == SEG_1) ? ch1_reg : '0;
        data_next.dvsr = (seg_reg == SEG_1) ? ch0_reg : CH_W'(1);
        data_next.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= s_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            ch0_reg <= s_ch0;
            ch1_reg <= s_ch1;
            seg_reg <= seg_next;
        end
        if (en_b) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/tlc_div_stage.sv =====
// ----------------------------------------------------------------------------
// tlc_div_stage
// one restoring division step, one ratio bit per stage
// ----------------------------------------------------------------------------
module tlc_div_stage import tlc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tlc_div_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tlc_div_t m_data
);

    logic          valid_reg;
    logic          en;
    tlc_div_t      data_reg;
    tlc_div_t      data_next;
    logic [CH_W:0] rem_sh;
    logic [CH_W:0] rem_sub;
    logic          ge;

    assign en      = !valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    assign rem_sh  = {s_data.rem, 1'b0};
    assign ge      = rem_sh >= {1'b0, s_data.dvsr};
    assign rem_sub = rem_sh - {1'b0, s_data.dvsr};

    always_comb begin
        data_next     = s_data;
        // remainder stays below the divisor, so it fits the channel width
        data_next.rem = ge ? rem_sub[CH_W-1:0] : rem_sh[CH_W-1:0];
        data_next.quo = {s_data.quo[IDX_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/tlc_pow_stage.sv =====
// ----------------------------------------------------------------------------
// tlc_pow_stage
// r^1.4 table lookup and the segment 1 ir product
// ----------------------------------------------------------------------------
module tlc_pow_stage import tlc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tlc_div_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tlc_fin_t m_data
);

    localparam tlc_pow_rom_t POW_ROM = tlc_pow_rom();

    logic             va_reg;
    logic             vb_reg;
    logic             en_a;
    logic             en_b;
    logic [POW_W-1:0] y_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [POS_W-1:0] pos_reg;
    logic [NEG_W-1:0] neg_reg;
    tlc_fin_t         data_reg;
    tlc_fin_t         data_next;

    assign en_b    = !vb_reg || m_ready;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;
    assign m_valid = vb_reg;
    assign m_data  = data_reg;

    always_comb begin
        data_next.seg = seg_reg;
        data_next.pos = pos_reg;
        if (seg_reg == SEG_1) begin
            data_next.neg = WIDE_W'(WIDE_W'(neg_reg) * WIDE_W'(y_reg));
        end else begin
            data_next.neg = {neg_reg, {Q_SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (en_a) begin
                va_reg <= s_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            y_reg   <= POW_ROM[s_data.quo];
            seg_reg <= s_data.seg;
            pos_reg <= s_data.pos;
            neg_reg <= s_data.neg;
        end
        if (en_b) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/tlc_finish.sv =====
// ----------------------------------------------------------------------------
// tlc_finish
// difference clamped at zero, scaled to output fraction bits, saturated
// ----------------------------------------------------------------------------
module tlc_finish import tlc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tlc_fin_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LUX_W-1:0] m_lux,
    output logic [SEG_W-1:0] m_seg
);

    logic              valid_reg;
    logic              en;
    logic [LUX_W-1:0]  lux_reg;
    logic [LUX_W-1:0]  lux_next;
    logic [SEG_W-1:0]  seg_reg;
    logic [WIDE_W-1:0] pos40;
    logic [WIDE_W-1:0] diff;
    logic [WIDE_W-1:0] scaled;

    assign en      = !valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg;
    assign m_lux   = lux_reg;
    assign m_seg   = seg_reg;

    assign pos40  = WIDE_W'({s_data.pos, {Q_SHIFT{1'b0}}});
    assign diff   = (pos40 > s_data.neg) ? pos40 - s_data.neg : '0;
    assign scaled = diff >> LUX_SHIFT;

    always_comb begin
        if (s_data.seg == SEG_ZERO || s_data.seg == SEG_HIGH) begin
            lux_next = '0;
        end else if (scaled > WIDE_W'(LUX_MAX)) begin
            lux_next = LUX_MAX;
        end else begin
            lux_next = scaled[LUX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lux_reg <= lux_next;
            seg_reg <= s_data.seg;
        end
    end

endmodule

// ===== rtl/core/two_channel_lux_calc.sv =====
// ----------------------------------------------------------------------------
// two_channel_lux_calc
// piecewise lux formula from broadband and infrared light sensor counts
// ----------------------------------------------------------------------------
// usage:
//   input beats carry one pair of adc counts, broadband in the low half of
//   s_axis_tdata and infrared in the high half. each input beat yields one
//   output beat with the illuminance (1/256 lux at the default fraction
//   width) in m_axis_tdata and the formula segment in m_axis_tuser.
//   the pipeline holds two classify stages, one restoring division stage
//   per ratio bit, the table lookup, the r^1.4 product and the output
//   register. throughput is one beat per cycle while the receiver takes
//   every result; every stage holds its own valid bit and advances whenever
//   its successor is free, so a stalled receiver only backs up the pipeline
//   as far as the bubbles allow and input keeps flowing until every stage
//   is full. a stall loses and repeats nothing.
//   reset clears all valid bits; the power table is a constant rom, so the
//   block accepts beats right after reset is released.
// ----------------------------------------------------------------------------
module two_channel_lux_calc import tlc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] broadband_count, [31:16] infrared_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [18:0] lux_value, [23:19] zero
    output logic [7:0]  m_axis_tuser    // [2:0] segment, [7:3] zero
);

    // handshake chain through the division steps, index 0 is the classify output
    logic [RATIO_FRAC_BITS:0] div_valid;
    logic [RATIO_FRAC_BITS:0] div_ready;
    tlc_div_t                 div_data [RATIO_FRAC_BITS+1];

    logic             fin_valid;
    logic             fin_ready;
    tlc_fin_t         fin_data;
    logic [LUX_W-1:0] lux;
    logic [SEG_W-1:0] seg;

    // ratio classification and first products
    tlc_classify u_classify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_ch0   (s_axis_tdata[15:0]),
        .s_ch1   (s_axis_tdata[31:16]),
        .m_valid (div_valid[0]),
        .m_ready (div_ready[0]),
        .m_data  (div_data[0])
    );

    // ir/broadband ratio, one quotient bit per stage
    for (genvar g = 0; g < RATIO_FRAC_BITS; g++) begin : g_div
        tlc_div_stage u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (div_valid[g]),
            .s_ready (div_ready[g]),
            .s_data  (div_data[g]),
            .m_valid (div_valid[g+1]),
            .m_ready (div_ready[g+1]),
            .m_data  (div_data[g+1])
        );
    end

    // r^1.4 lookup and segment 1 product
    tlc_pow_stage u_pow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (div_valid[RATIO_FRAC_BITS]),
        .s_ready (div_ready[RATIO_FRAC_BITS]),
        .s_data  (div_data[RATIO_FRAC_BITS]),
        .m_valid (fin_valid),
        .m_ready (fin_ready),
        .m_data  (fin_data)
    );

    // clamp, scale, saturate and hold the result for the receiver
    tlc_finish u_finish (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (fin_valid),
        .s_ready (fin_ready),
        .s_data  (fin_data),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_lux   (lux),
        .m_seg   (seg)
    );

    assign m_axis_tdata = {{(24 - LUX_W){1'b0}}, lux};
    assign m_axis_tuser = {{(8 - SEG_W){1'b0}}, seg};

`ifndef NO_ASSERTIONS
    // ratio rom index stays inside the table for segment 1
    a_rom_index: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[RATIO_FRAC_BITS] && div_data[RATIO_FRAC_BITS].seg == SEG_1
        |-> div_data[RATIO_FRAC_BITS].quo <= IDX_W'(ROM_DEPTH - 1))
        else $error("ratio index beyond power table");

    // other segments must not feed the divider anything but zero over one
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[0] && div_data[0].seg != SEG_1
        |-> div_data[0].rem == '0 && div_data[0].dvsr == CH_W'(1))
        else $error("divider fed outside segment 1");

    // an empty output register lets the whole chain take a beat
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // broadband zero and ratio above range give zero lux
    a_zero_lux: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (seg == SEG_ZERO || seg == SEG_HIGH) |-> lux == '0)
        else $error("nonzero lux outside formula segments");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream-level check of the two-channel lux calculator: drives count pairs
// with random gaps, predicts each lux value and segment independently, and
// compares every output beat in order against the predicted results
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [tlc_pkg::LUX_W-1:0] lux;
    logic [tlc_pkg::SEG_W-1:0] seg;
} lux_result_t;

class lux_scoreboard;

    lux_result_t pending_lux[$];
    int          errors;
    int          checked;
    int          seg_hits[6];
    int          clamped;

    // largest z below 2^12 with z^5 <= v, built one bit at a time
    function longint unsigned root5_q12(longint unsigned v);
        longint unsigned z;
        longint unsigned cand;
        longint unsigned sq;
        z = 0;
        for (int b = 11; b >= 0; b--) begin
            cand = z | (64'd1 << b);
            sq   = cand * cand;
            if (sq * sq * cand <= v) begin
                z = cand;
            end
        end
        return z;
    endfunction

    function lux_result_t predict_lux(logic [15:0] bb, logic [15:0] ir);
        lux_result_t     res;
        longint unsigned c0;
        longint unsigned c1;
        longint unsigned ratio;
        longint unsigned r16;
        longint unsigned pw;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned diff;
        int              frac;
        c0   = bb;
        c1   = ir;
        pos  = 0;
        neg  = 0;
        frac = 2 * tlc_pkg::Q_SHIFT;
        res.lux = '0;
        if (c0 == 0) begin
            res.seg = tlc_pkg::SEG_ZERO;
        end else if (2 * c1 <= c0) begin
            // r^1.4 as r * r^0.4, ratio truncated to the block's fraction width
            ratio = (c1 << tlc_pkg::RATIO_FRAC_BITS) / c0;
            r16   = ratio << (16 - tlc_pkg::RATIO_FRAC_BITS);
            pw    = (r16 * root5_q12((r16 * r16) << 28)) >> 8;
            pos   = (64'(tlc_pkg::K_A0) * c0) << tlc_pkg::Q_SHIFT;
            neg   = 64'(tlc_pkg::K_A1) * c0 * pw;
            res.seg = tlc_pkg::SEG_1;
        end else if (100 * c1 <= 61 * c0) begin
            pos  = 64'(tlc_pkg::K_B0) * c0;
            neg  = 64'(tlc_pkg::K_B1) * c1;
            frac = tlc_pkg::Q_SHIFT;
            res.seg = tlc_pkg::SEG_2;
        end else if (100 * c1 <= 80 * c0) begin
            pos  = 64'(tlc_pkg::K_C0) * c0;
            neg  = 64'(tlc_pkg::K_C1) * c1;
            frac = tlc_pkg::Q_SHIFT;
            res.seg = tlc_pkg::SEG_3;
        end else if (100 * c1 <= 130 * c0) begin
            pos  = 64'(tlc_pkg::K_D0) * c0;
            neg  = 64'(tlc_pkg::K_D1) * c1;
            frac = tlc_pkg::Q_SHIFT;
            res.seg = tlc_pkg::SEG_4;
        end else begin
            res.seg = tlc_pkg::SEG_HIGH;
        end
        if (res.seg != tlc_pkg::SEG_ZERO && res.seg != tlc_pkg::SEG_HIGH) begin
            diff = (pos > neg) ? pos - neg : 64'd0;
            diff = diff >> (frac - tlc_pkg::LUX_FRAC_BITS);
            if (pos <= neg || diff > 64'(tlc_pkg::LUX_MAX)) begin
                clamped++;
            end
            res.lux = (diff > 64'(tlc_pkg::LUX_MAX)) ? tlc_pkg::LUX_MAX
                                                      : diff[tlc_pkg::LUX_W-1:0];
        end
        return res;
    endfunction

    function void note_pair(logic [15:0] bb, logic [15:0] ir);
        lux_result_t res;
        res = predict_lux(bb, ir);
        seg_hits[res.seg]++;
        pending_lux.push_back(res);
    endfunction

    function void check_result(logic [tlc_pkg::LUX_W-1:0] lux,
                               logic [tlc_pkg::SEG_W-1:0] seg);
        lux_result_t want;
        if (pending_lux.size() == 0) begin
            $error("output beat with no input pending: lux_value %0d segment %0d",
                   lux, seg);
            errors++;
        end else begin
            want = pending_lux.pop_front();
            checked++;
            if (lux !== want.lux) begin
                $error("lux_value mismatch: expected %0d actual %0d", want.lux, lux);
                errors++;
            end
            if (seg !== want.seg) begin
                $error("segment mismatch: expected %0d actual %0d", want.seg, seg);
                errors++;
            end
        end
    endfunction

    function int outstanding();
        return pending_lux.size();
    endfunction

endclass

module tb_top;
    import tlc_pkg::*;

    localparam int LATENCY     = RATIO_FRAC_BITS + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PAIRS = 926;
    localparam int HOLD_CYCLES = 400;
    localparam int N_CORNERS   = 24;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] broadband_count, [31:16] infrared_count
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [18:0] lux_value, [23:19] zero
    logic [7:0]  m_axis_tuser;         // [2:0] segment, [7:3] zero

    lux_scoreboard lux_board;

    int cycle_count;
    int input_stall_cycles;
    int out_beats;
    bit hold_request;

    // corner pairs: zero channels, full scale, exact breakpoints and one past them
    int unsigned corner_bb [N_CORNERS] = '{
        0,     0,     1,     65535, 65535, 2,     65534, 65535,
        65535, 100,   100,   100,   100,   100,   100,   65535,
        1,     50000, 1,     3,     65535, 1000,  40000, 40000
    };
    int unsigned corner_ir [N_CORNERS] = '{
        0,     65535, 0,     0,     1,     1,     32767, 32767,
        32768, 61,    62,    80,    81,    130,   131,   65535,
        65535, 65000, 1,     1,     21845, 499,   24400, 32000
    };

    two_channel_lux_calc DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 unit clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // gap length per beat: 0 busy, 1 fully random, 2 mostly back to back
    function automatic int draw_gap(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 12);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    // one input beat; the gap is spent before the beat is offered so that
    // valid stays high across back to back beats
    task automatic drive_pair(logic [15:0] bb, logic [15:0] ir, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ir, bb};
        do @(posedge aclk); while (!s_axis_tready);
        lux_board.note_pair(bb, ir);
    endtask

    // random pair, weighted toward the segment breakpoints
    task automatic draw_pair(output logic [15:0] bb, output logic [15:0] ir);
        int unsigned kind;
        int unsigned c0;
        int unsigned brk;
        int          c1;
        kind = $urandom_range(0, 9);
        c0   = $urandom_range(1, 65535) >> $urandom_range(0, 15);
        if (c0 == 0) begin
            c0 = 1;
        end
        c1 = 0;
        if (kind <= 2) begin
            // full range on both channels, every bit moves
            c0 = $urandom_range(0, 65535);
            c1 = $urandom_range(0, 65535);
        end else if (kind <= 6) begin
            // near a breakpoint, within one count either side
            case ($urandom_range(0, 3))
                0: brk = 50;
                1: brk = 61;
                2: brk = 80;
                default: brk = 130;
            endcase
            c1 = int'((c0 * brk) / 100) + int'($urandom_range(0, 2)) - 1;
        end else if (kind == 7) begin
            // inside the power-law segment
            c1 = $urandom_range(0, c0 / 2);
        end else if (kind == 8) begin
            c0 = $urandom_range(0, 15);
            c1 = $urandom_range(0, 15);
        end else begin
            case ($urandom_range(0, 2))
                0: c0 = 0;
                1: c1 = 0;
                default: begin
                    c0 = 65535 - $urandom_range(0, 3);
                    c1 = $urandom_range(0, 65535);
                end
            endcase
        end
        if (c1 < 0) begin
            c1 = 0;
        end else if (c1 > 65535) begin
            c1 = 65535;
        end
        bb = c0[15:0];
        ir = c1[15:0];
    endtask

    // cycle counter, input backpressure tally and timeout
    initial begin
        cycle_count        = 0;
        input_stall_cycles = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
            if (s_axis_tvalid && !s_axis_tready && aresetn) begin
                input_stall_cycles++;
            end
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, lux_board.outstanding());
        $display("tb_top NOT OK");
        $finish;
    end

    // receiver: random ready gaps, mode redrawn every 64 beats, plus one
    // long hold-off on request so the pipeline backs up into the input
    initial begin
        int rx_mode;
        int stall;
        rx_mode = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (out_beats % 64 == 0) begin
                    rx_mode = $urandom_range(0, 2);
                end
                stall = draw_gap(rx_mode);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            out_beats++;
            lux_board.check_result(m_axis_tdata[LUX_W-1:0], m_axis_tuser[SEG_W-1:0]);
        end
    end

    // stimulus and end of run
    initial begin
        logic [15:0] bb;
        logic [15:0] ir;
        int          tx_mode;
        int          burst_left;
        lux_board    = new();
        hold_request = 1'b0;
        out_beats    = 0;
        tx_mode      = 0;
        burst_left   = 0;

        // synchronous reset, then release
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners, first half back to back
        for (int i = 0; i < N_CORNERS; i++) begin
            drive_pair(corner_bb[i][15:0], corner_ir[i][15:0],
                       (i < N_CORNERS / 2) ? 0 : $urandom_range(0, 12));
        end

        // let everything drain before the random part
        s_axis_tvalid <= 1'b0;
        while (lux_board.outstanding() != 0) @(posedge aclk);

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if (i % 50 == 0) begin
                tx_mode = $urandom_range(0, 2);
            end
            // long receiver hold-off while the sender keeps streaming
            if (i == 300) begin
                hold_request = 1'b1;
                burst_left   = 80;
            end
            // sender pause until every result is back
            if (i == 600) begin
                s_axis_tvalid <= 1'b0;
                while (lux_board.outstanding() != 0) @(posedge aclk);
            end
            draw_pair(bb, ir);
            if (burst_left > 0) begin
                burst_left--;
                drive_pair(bb, ir, 0);
            end else begin
                drive_pair(bb, ir, draw_gap(tx_mode));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then watch a little longer for stray beats
        while (lux_board.outstanding() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("%0d lux results checked; segments zero/1/2/3/4/high: %0d/%0d/%0d/%0d/%0d/%0d",
                 lux_board.checked, lux_board.seg_hits[0], lux_board.seg_hits[1],
                 lux_board.seg_hits[2], lux_board.seg_hits[3], lux_board.seg_hits[4],
                 lux_board.seg_hits[5]);
        $display("input held off %0d cycles, %0d results clamped or saturated",
                 input_stall_cycles, lux_board.clamped);
        if (lux_board.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
